// File: src/clock_page_replacement_macros.svh
// Assertion macros used by the checker file of the clock page replacement block.
`ifndef CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock page replacement check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock page replacement check failed");

`endif

// File: src/cpr_pkg.sv
// Types and constants shared by the clock page replacement modules.
package cpr_pkg;

    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int SLOT_W    = 6;
    localparam int PAGE_BITS = 20;
    localparam int RK_W      = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REFER  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_SLOT = 2'd3;

    // Kinds of result that the controller asks the datapath to build.
    localparam logic [RK_W-1:0] RK_NONE   = 3'd0;
    localparam logic [RK_W-1:0] RK_FULL   = 3'd1;
    localparam logic [RK_W-1:0] RK_EMPTY  = 3'd2;
    localparam logic [RK_W-1:0] RK_REF    = 3'd3;
    localparam logic [RK_W-1:0] RK_INS    = 3'd4;
    localparam logic [RK_W-1:0] RK_VICTIM = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [PAGE_BITS-1:0] page_number;
        logic [SLOT_W-1:0]    slot_index;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [SLOT_W-1:0]    result_slot;
        logic [PAGE_BITS-1:0] victim_page;
    } rsp_t;

    typedef struct packed {
        logic            load;
        logic            pos_zero;
        logic            pos_hand;
        logic            step;
        logic            ins_write;
        logic            ref_set;
        logic            clr_ref;
        logic            evict;
        logic            res_we;
        logic [RK_W-1:0] res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            ref_ok;
        logic            cur_valid;
        logic            cur_ref;
        logic            last_pos;
        logic            scan_done;
    } dp_status_t;

endpackage

// File: src/cpr_ctrl.sv
// Sequencing state machine of the clock page replacement block.
module cpr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cpr_pkg::dp_status_t stat,
    output cpr_pkg::ctrl_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_INS    = 3'd2;
    localparam logic [2:0] S_EVI    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    cpr_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_we   = 1'b1;
                            cmd.res_kind = cpr_pkg::RK_FULL;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.pos_zero = 1'b1;
                            state_next   = S_INS;
                        end
                    end
                    cpr_pkg::OP_REFER:
                    begin
                        cmd.ref_set  = stat.ref_ok;
                        cmd.res_we   = 1'b1;
                        cmd.res_kind = cpr_pkg::RK_REF;
                        state_next   = S_RESP;
                    end
                    cpr_pkg::OP_EVICT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_we   = 1'b1;
                            cmd.res_kind = cpr_pkg::RK_EMPTY;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.pos_hand = 1'b1;
                            state_next   = S_EVI;
                        end
                    end
                    default:
                    begin
                        cmd.res_we   = 1'b1;
                        cmd.res_kind = cpr_pkg::RK_NONE;
                        state_next   = S_RESP;
                    end
                endcase
            end
            S_INS:
            begin
                if (!stat.cur_valid)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.res_we    = 1'b1;
                    cmd.res_kind  = cpr_pkg::RK_INS;
                    state_next    = S_RESP;
                end
                else if (stat.last_pos)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_kind = cpr_pkg::RK_FULL;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_EVI:
            begin
                if (stat.cur_valid && !stat.cur_ref)
                begin
                    cmd.evict  = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    cmd.clr_ref = stat.cur_valid;
                    if (stat.scan_done)
                    begin
                        cmd.res_we   = 1'b1;
                        cmd.res_kind = cpr_pkg::RK_EMPTY;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.res_we   = 1'b1;
                cmd.res_kind = cpr_pkg::RK_VICTIM;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = !((state_reg == S_IDLE) || (state_reg == S_RESP));
    assign done = (state_reg == S_RESP);

endmodule

// File: src/cpr_datapath.sv
// Slot store, hand, scan position and result register of the clock page replacement block.
module cpr_datapath
#(
    parameter int SLOTS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpr_pkg::req_t       req,
    input  cpr_pkg::ctrl_cmd_t  cmd,
    output cpr_pkg::dp_status_t stat,
    output cpr_pkg::rsp_t       rsp
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int STEP_W = $clog2(2 * SLOTS + 1);
    localparam int EXT_W  = (CNT_W > cpr_pkg::SLOT_W) ? CNT_W : cpr_pkg::SLOT_W;

    // Control state.
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOTS-1:0]  ref_reg, ref_next;
    logic [IDX_W-1:0]  hand_reg, hand_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    // Payload.
    cpr_pkg::req_t              req_reg, req_next;
    cpr_pkg::rsp_t              rsp_reg, rsp_next;
    logic [cpr_pkg::PAGE_BITS-1:0] rdata_reg;
    logic [cpr_pkg::PAGE_BITS-1:0] tag_mem [SLOTS];

    logic [EXT_W-1:0] slot_ext;
    logic [IDX_W-1:0] ref_idx;
    logic             ref_ok;
    logic             last_pos;
    logic [IDX_W-1:0] pos_step;

    assign slot_ext = EXT_W'(req_reg.slot_index);
    assign ref_idx  = slot_ext[IDX_W-1:0];
    assign ref_ok   = (slot_ext < EXT_W'(SLOTS)) && valid_reg[ref_idx];
    assign last_pos = (pos_reg == IDX_W'(SLOTS - 1));
    assign pos_step = last_pos ? '0 : pos_reg + 1'b1;

    assign stat.op        = req_reg.op;
    assign stat.full      = (count_reg == CNT_W'(SLOTS));
    assign stat.empty     = (count_reg == '0);
    assign stat.ref_ok    = ref_ok;
    assign stat.cur_valid = valid_reg[pos_reg];
    assign stat.cur_ref   = ref_reg[pos_reg];
    assign stat.last_pos  = last_pos;
    assign stat.scan_done = (steps_reg == STEP_W'(2 * SLOTS));

    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        hand_next  = hand_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        steps_next = steps_reg;
        req_next   = cmd.load ? req : req_reg;
        rsp_next   = rsp_reg;

        if (cmd.pos_zero)
        begin
            pos_next = '0;
        end
        if (cmd.pos_hand)
        begin
            pos_next   = hand_reg;
            steps_next = '0;
        end
        if (cmd.step)
        begin
            pos_next   = pos_step;
            steps_next = steps_reg + 1'b1;
        end
        if (cmd.ins_write)
        begin
            valid_next[pos_reg] = 1'b1;
            ref_next[pos_reg]   = 1'b0;
            count_next          = count_reg + 1'b1;
        end
        if (cmd.ref_set)
        begin
            ref_next[ref_idx] = 1'b1;
        end
        if (cmd.clr_ref)
        begin
            ref_next[pos_reg] = 1'b0;
        end
        if (cmd.evict)
        begin
            valid_next[pos_reg] = 1'b0;
            ref_next[pos_reg]   = 1'b0;
            count_next          = count_reg - 1'b1;
            hand_next           = pos_step;
        end

        if (cmd.res_we)
        begin
            rsp_next = '0;
            case (cmd.res_kind)
                cpr_pkg::RK_FULL:
                begin
                    rsp_next.status = cpr_pkg::ST_FULL;
                end
                cpr_pkg::RK_EMPTY:
                begin
                    rsp_next.status = cpr_pkg::ST_EMPTY;
                end
                cpr_pkg::RK_REF:
                begin
                    rsp_next.status      = ref_ok ? cpr_pkg::ST_OK : cpr_pkg::ST_BAD_SLOT;
                    rsp_next.result_slot = req_reg.slot_index;
                end
                cpr_pkg::RK_INS:
                begin
                    rsp_next.status      = cpr_pkg::ST_OK;
                    rsp_next.result_slot = cpr_pkg::SLOT_W'(pos_reg);
                end
                cpr_pkg::RK_VICTIM:
                begin
                    rsp_next.status      = cpr_pkg::ST_OK;
                    rsp_next.result_slot = cpr_pkg::SLOT_W'(pos_reg);
                    rsp_next.victim_page = rdata_reg;
                end
                default:
                begin
                    rsp_next.status = cpr_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ref_reg   <= '0;
            hand_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            steps_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            hand_reg  <= hand_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Page tag store: one write port for inserts, one registered read at the scan position.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            tag_mem[pos_reg] <= req_reg.page_number;
        end
        rdata_reg <= tag_mem[pos_reg];
    end

    assign rsp = rsp_reg;

endmodule

// File: src/clock_page_replacement.sv
// Top level of the clock (second-chance) page replacement block.
// A transaction is presented on request (op, page_number, slot_index) with start
// held high; it is taken at a rising edge where start is high and busy is low.
// Every transaction yields exactly one response, shown on response for a single
// cycle while done is high; the receiver must take it then, as it cannot stall.
// Insert searches the slots from slot zero for the first free one, one slot per
// cycle, and reports full if it reaches the last slot without finding one.
// Reference, and insert or evict refused at decode, go straight to the response.
// Evict sweeps from the hand one slot per cycle, clearing referenced bits as it
// passes, then reads the victim's page from the tag memory. The walk uses a
// single scan position over the valid and referenced bits.
// A new transaction may be accepted in the cycle that done is high, so
// transactions can follow one another with no gap between them.
// Reset clears every valid and referenced bit, the hand and the resident count
// at once; the page tags are not cleared, as only valid slots' tags are reported.
module clock_page_replacement
#(
    parameter int SLOTS = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cpr_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output cpr_pkg::rsp_t response
);

    // Command and status bundles between the sequencer and the datapath.
    cpr_pkg::ctrl_cmd_t  cmd;
    cpr_pkg::dp_status_t stat;

    // The sequencer walks a transaction through decode, any scan and response.
    cpr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath owns the slot state, the tag memory and the response register.
    cpr_datapath
    #(
        .SLOTS (SLOTS)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (request),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (response)
    );

endmodule

// File: src/cpr_checker.sv
// Port-level checks for the clock page replacement block, with its bind.
`include "clock_page_replacement_macros.svh"

module cpr_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input cpr_pkg::rsp_t response
);

    // An accepted transaction keeps the block busy in the following cycle.
    `CPR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)

    // The response strobe never lasts more than one cycle.
    `CPR_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // While a response is shown the block is ready to take a new transaction.
    `CPR_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy)

    // A victim page is reported only with a good status.
    `CPR_ASSERT_NOW(a_victim_ok, clk, rst_n, done && (response.victim_page != '0),
                    response.status == cpr_pkg::ST_OK)

    // The full and empty errors carry a zero slot.
    `CPR_ASSERT_NOW(a_err_zero_slot, clk, rst_n,
                    done && ((response.status == cpr_pkg::ST_FULL) ||
                             (response.status == cpr_pkg::ST_EMPTY)),
                    response.result_slot == '0)

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);
